FILE: design/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ACTION_W      = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int TOTAL_W       = 7;
    localparam int FILL_W        = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LIST_FWD   = 3'd4,
        ACT_LIST_BWD   = 3'd5,
        ACT_COUNT      = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  value;
        logic [TOTAL_W-1:0]         total;
        logic                       last;
    } t_result;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              pop;
    } t_fifo_stat;

endpackage

FILE: design/deq_if.sv
interface deq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::ACTION_W-1:0]         action;
    logic signed [deq_pkg::VALUE_W-1:0]   value_in;

    modport source (output valid, action, value_in, input ready);
    modport sink   (input valid, action, value_in, output ready);
endinterface

interface deq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::STATUS_W-1:0]         status;
    logic signed [deq_pkg::VALUE_W-1:0]   value_out;
    logic [deq_pkg::TOTAL_W-1:0]          element_total;
    logic                                 last;

    modport source (output valid, status, value_out, element_total, last, input ready);
    modport sink   (input valid, status, value_out, element_total, last, output ready);
endinterface

FILE: design/double_ended_queue_core.sv
// Channel   Dir  Payload                                     Handshake
// i_req     in   action, value_in                            valid/ready
// o_res     out  status, value_out, element_total, last      valid/ready
//
// Push, pop, count and unused actions end when accepted; a pop's value comes
// from the element RAM in the next cycle and lands in a two-entry result FIFO.
// A list holds the request side until its last element is read, reading one
// RAM entry per cycle while FIFO credit allows, as the RAM has one read port.
// Synchronous active-low reset clears front, count and control; RAM needs no
// clearing. A stalled result side holds off new reads by FIFO credit.
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_in_if.sink     i_req,
    deq_out_if.source  o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEP_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_P = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    typedef enum logic {S_IDLE, S_LIST} t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_front, n_front;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx,   n_idx;
    logic                 r_fwd,   n_fwd;
    logic                 r_pend_valid;
    logic                 r_pend_mem, n_pend_mem;
    deq_pkg::t_result     r_pend,  n_res;

    logic                 issue;
    logic                 issue_ok;
    logic                 accept;
    logic [2:0]           occ;
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [deq_pkg::VALUE_W-1:0] rdata;
    logic [CW-1:0]        list_off;
    logic                 list_last;
    deq_pkg::t_result     push_data;
    deq_pkg::t_fifo_stat  fstat;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= DEP_W) begin
            sum = sum - DEP_W;
        end
        return sum[AW-1:0];
    endfunction

    // Credit: after this cycle at most one result may sit in the FIFO, so
    // whatever is issued now always has room when it arrives.
    assign occ      = 3'(fstat.fill) + 3'(r_pend_valid) - 3'(fstat.pop);
    assign issue_ok = (occ <= 3'd1);

    assign i_req.ready = (r_state == S_IDLE) && issue_ok;
    assign accept      = i_req.valid && i_req.ready;

    assign list_off  = r_fwd ? CW'(r_idx) : (r_count - CW'(1) - CW'(r_idx));
    assign list_last = (CW'(r_idx) == (r_count - CW'(1)));

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_fwd      = r_fwd;
        n_pend_mem = 1'b0;
        issue      = 1'b0;
        we         = 1'b0;
        waddr      = slot_of(r_front, AW'(r_count));
        raddr      = r_front;
        n_res.status = deq_pkg::ST_OK;
        n_res.value  = '0;
        n_res.last   = 1'b1;
        n_res.total  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (deq_pkg::t_action'(i_req.action))
                        deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
                            issue = 1'b1;
                            if (r_count == FULL_C) begin
                                n_res.status = deq_pkg::ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_req.action == deq_pkg::ACT_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? LAST_P : r_front - AW'(1);
                                    waddr   = n_front;
                                end
                            end
                        end
                        deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
                            issue = 1'b1;
                            if (r_count == '0) begin
                                n_res.status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_pend_mem = 1'b1;
                                n_count    = r_count - CW'(1);
                                if (i_req.action == deq_pkg::ACT_POP_FRONT) begin
                                    raddr   = r_front;
                                    n_front = (r_front == LAST_P) ? '0 : r_front + AW'(1);
                                end else begin
                                    raddr = slot_of(r_front, AW'(r_count - CW'(1)));
                                end
                            end
                        end
                        deq_pkg::ACT_LIST_FWD, deq_pkg::ACT_LIST_BWD: begin
                            if (r_count == '0) begin
                                issue        = 1'b1;
                                n_res.status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_LIST;
                                n_idx   = '0;
                                n_fwd   = (i_req.action == deq_pkg::ACT_LIST_FWD);
                            end
                        end
                        deq_pkg::ACT_COUNT: begin
                            issue = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (issue_ok) begin
                    issue      = 1'b1;
                    n_pend_mem = 1'b1;
                    raddr      = slot_of(r_front, AW'(list_off));
                    n_res.last = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.total = deq_pkg::TOTAL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front      <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_fwd        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_mem   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front      <= n_front;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_fwd        <= n_fwd;
            r_pend_valid <= issue;
            r_pend_mem   <= n_pend_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend <= n_res;
        end
    end

    // Only one action runs per cycle and a push ignores the read data, so a read
    // that meets a write to the same entry in the same cycle is never consumed.
    deq_ram #(
        .WIDTH (deq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.value_in),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        push_data       = r_pend;
        push_data.value = r_pend_mem ? rdata : '0;
    end

    deq_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pend_valid),
        .i_data  (push_data),
        .o_stat  (fstat),
        .o_res   (o_res)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("element count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= LAST_P)
        else $error("front position out of range");

    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (fstat.fill <= deq_pkg::FILL_W'(1)))
        else $error("result arrives with no room in the FIFO");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(accept) && $past(r_count) != '0 &&
         ($past(i_req.action) == deq_pkg::ACT_POP_FRONT ||
          $past(i_req.action) == deq_pkg::ACT_POP_BACK))
        |-> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not reduce the count by one");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && issue && list_last) |=> (r_state == S_IDLE))
        else $error("list did not return to idle after its last element");

endmodule

FILE: design/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = deq_pkg::VALUE_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/deq_res_fifo.sv
module deq_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  deq_pkg::t_result     i_data,
    output deq_pkg::t_fifo_stat  o_stat,
    deq_out_if.source            o_res
);

    deq_pkg::t_result          r_mem [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [deq_pkg::FILL_W-1:0] r_fill;
    logic                      pop;
    deq_pkg::t_result          head;

    assign head = r_mem[r_rp];
    assign pop  = o_res.valid && o_res.ready;

    assign o_res.valid         = (r_fill != '0);
    assign o_res.status        = head.status;
    assign o_res.value_out     = head.value;
    assign o_res.element_total = head.total;
    assign o_res.last          = head.last;

    assign o_stat.fill = r_fill;
    assign o_stat.pop  = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + deq_pkg::FILL_W'(i_push) - deq_pkg::FILL_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 150;
    localparam int RANDOM_REQUESTS = 300;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    class deque_scoreboard;
        logic signed [VALUE_W-1:0] slots [DEPTH];
        int unsigned front_pos;
        int unsigned held;
        t_result expected_results [$];
        int mismatches;

        function new();
            front_pos = 0;
            held = 0;
            mismatches = 0;
        endfunction

        function void add_result(t_status st, logic signed [VALUE_W-1:0] v, logic lst);
            t_result r;
            r.status = st;
            r.value = v;
            r.total = held[TOTAL_W-1:0];
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        function int unsigned slot_at(int unsigned offset);
            return (front_pos + offset) % DEPTH;
        endfunction

        function void note_request(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
            logic signed [VALUE_W-1:0] v;
            int unsigned off;
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        add_result(ST_FULL, '0, 1'b1);
                    end else begin
                        if (act == ACT_PUSH_FRONT) begin
                            front_pos = (front_pos + DEPTH - 1) % DEPTH;
                            slots[front_pos] = val;
                        end else begin
                            slots[slot_at(held)] = val;
                        end
                        held++;
                        add_result(ST_OK, '0, 1'b1);
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    if (held == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        if (act == ACT_POP_FRONT) begin
                            v = slots[front_pos];
                            front_pos = (front_pos + 1) % DEPTH;
                        end else begin
                            v = slots[slot_at(held - 1)];
                        end
                        held--;
                        add_result(ST_OK, v, 1'b1);
                    end
                end
                ACT_LIST_FWD, ACT_LIST_BWD: begin
                    if (held == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < held; i++) begin
                            off = (act == ACT_LIST_FWD) ? i : held - 1 - i;
                            add_result(ST_OK, slots[slot_at(off)], i + 1 == held);
                        end
                    end
                end
                ACT_COUNT: add_result(ST_OK, '0, 1'b1);
                default: ;
            endcase
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] v,
                          logic [TOTAL_W-1:0] tot, logic lst);
            t_result want;
            if (expected_results.size() == 0) begin
                report("result with nothing outstanding, value", v, 0);
            end else begin
                want = expected_results.pop_front();
                if (st !== want.status) report("status", st, want.status);
                if (v !== want.value) report("value_out", v, want.value);
                if (tot !== want.total) report("element_total", tot, want.total);
                if (lst !== want.last) report("last", lst, want.last);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit quiet_send;
    bit quiet_recv;
    int hold_ask;
    int hold_left;
    int stall_left;
    int idle_cycles;
    deque_scoreboard sb;

    deq_in_if req_if ();
    deq_out_if res_if ();

    double_ended_queue_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    initial clk = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: random stall after each result, plus an occasional long hold.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.status, res_if.value_out, res_if.element_total,
                                res_if.last);
                stall_left = quiet_recv ? 0 : $urandom_range(0, 4);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_ask > 0) begin
                hold_left = hold_ask;
                hold_ask = 0;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            res_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("testbench: done, errors");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.action <= act;
        req_if.value_in <= val;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(act, val);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() > 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) != 0) return $urandom;
        case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        if (r < 88) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        if (r < 94) return $urandom_range(0, 1) ? ACT_LIST_BWD : ACT_LIST_FWD;
        if (r < 97) return ACT_COUNT;
        return ACT_UNUSED;
    endfunction

    initial begin
        t_phase phase;
        int random_sent;
        int linger;
        int mixed_left;
        int push_pct;
        logic [ACTION_W-1:0] act;

        sb = new();
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        hold_ask = 0;
        hold_left = 0;
        stall_left = 0;
        idle_cycles = 0;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.action <= ACT_COUNT;
        req_if.value_in <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: pops and lists report empty, count reports zero.
        send_request(ACT_COUNT, '0);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_BACK, '0);
        send_request(ACT_LIST_FWD, '0);
        send_request(ACT_LIST_BWD, '0);
        send_request(ACT_UNUSED, VAL_MAX);
        // The first push to the front wraps the front position below zero.
        send_request(ACT_PUSH_FRONT, VAL_MIN);
        send_request(ACT_PUSH_BACK, VAL_MAX);
        send_request(ACT_PUSH_FRONT, '0);
        send_request(ACT_PUSH_BACK, '1);
        send_request(ACT_LIST_FWD, '0);
        send_request(ACT_LIST_BWD, '0);
        send_request(ACT_COUNT, VAL_MIN);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_BACK, '0);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_BACK, '0);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_PUSH_BACK, pick_value());
        send_request(ACT_UNUSED, '0);
        send_request(ACT_COUNT, '0);
        wait_drained();

        // Hold the result side while requests keep coming, so the input stalls.
        hold_ask = LONG_HOLD;
        quiet_send = 1'b1;
        for (int i = 0; i < 6; i++) send_request(ACT_PUSH_BACK, pick_value());
        send_request(ACT_LIST_FWD, '0);
        for (int i = 0; i < 6; i++) send_request(ACT_COUNT, '0);
        quiet_send = 1'b0;
        wait_drained();

        phase = PH_FILL;
        random_sent = 0;
        linger = 0;
        mixed_left = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            case (phase)
                PH_FILL: push_pct = 75;
                PH_DRAIN: push_pct = 20;
                default: push_pct = 50;
            endcase
            act = pick_action(push_pct);
            send_request(act, pick_value());
            if (act != ACT_UNUSED) random_sent++;

            // Stay a few requests at full or empty before turning around.
            case (phase)
                PH_FILL: if (sb.held == DEPTH && ++linger > 4) phase = PH_DRAIN;
                PH_DRAIN: if (sb.held == 0 && ++linger > 4) begin
                    phase = PH_MIXED;
                    mixed_left = 40;
                end
                default: if (--mixed_left <= 0) phase = PH_FILL;
            endcase
            if ((phase == PH_MIXED && mixed_left == 40) ||
                (phase == PH_DRAIN && linger == 5)) begin
                linger = 0;
                wait_drained();
                quiet_send = ($urandom_range(0, 3) == 0);
                quiet_recv = ($urandom_range(0, 3) == 0);
            end
            if (random_sent == 150) hold_ask = LONG_HOLD;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
